@@ sv/image_marker_scanner_core_macros.svh @@
// assertion macros for the image marker scanner core
// expects signals named clock and reset in the scope of each use
`ifndef IMAGE_MARKER_SCANNER_CORE_MACROS_SVH
`define IMAGE_MARKER_SCANNER_CORE_MACROS_SVH

// general property check, off while reset is high
`define IMSC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition in a cycle implies a consequence in the next
`define IMSC_ASSERT_NEXT(lbl, cond, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/imsc_pkg.sv @@
// shared types and marker constants for the image marker scanner
// no dependencies
`default_nettype none

package imsc_pkg;

   // marker bytes
   localparam logic [7:0] MARK_FF  = 8'hFF;
   localparam logic [7:0] MARK_SOI = 8'hD8;
   localparam logic [7:0] MARK_EOI = 8'hD9;
   localparam logic [7:0] CH_G     = 8'h47;
   localparam logic [7:0] CH_I     = 8'h49;
   localparam logic [7:0] CH_F     = 8'h46;
   localparam logic [7:0] CH_8     = 8'h38;

   // one input word as held in the input register
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       first_item;
      logic [6:0] payload_offset;
      logic       last_item;
      logic       fin_flag;
   } item_type;

   // one result word
   typedef struct packed {
      logic        start_found;
      logic [15:0] start_offset;
      logic        end_found;
      logic [15:0] end_offset;
   } result_type;

endpackage

`default_nettype wire

@@ sv/imsc_in_stage.sv @@
// input register for the image marker scanner
// depends on imsc_pkg
`default_nettype none

module imsc_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire imsc_pkg::item_type in_item,
   input  wire logic              step,
   output logic                   held_valid,
   output imsc_pkg::item_type     held_item
);

   logic               valid_ff;
   logic               valid_in;
   imsc_pkg::item_type item_ff;

   // room when empty or when the held word moves on this cycle
   assign in_ready   = !valid_ff || step;
   assign valid_in   = (in_valid && in_ready) || (valid_ff && !step);
   assign held_valid = valid_ff;
   assign held_item  = item_ff;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

`default_nettype wire

@@ sv/imsc_scan.sv @@
// marker scan state and detection logic
// depends on imsc_pkg
`default_nettype none

module imsc_scan (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire imsc_pkg::item_type item,
   output imsc_pkg::result_type    result
);

   logic [23:0] window_ff, window_in;
   logic [1:0]  fill_ff, fill_in;
   logic [15:0] pos_ff, pos_in;
   logic        sfound_ff, sfound_in;
   logic [15:0] soff_ff, soff_in;
   logic        efound_ff, efound_in;
   logic [15:0] eoff_ff, eoff_in;

   logic [23:0] win_eff;
   logic [1:0]  fill_eff;
   logic [15:0] pos_eff;
   logic        sfound_eff, efound_eff;
   logic [15:0] soff_eff, eoff_eff;
   logic [7:0]  b1, b2, b3, cur;
   logic        hit_soi, hit_gif, hit_eoi;

   // first word restarts the packet
   always_comb begin
      if (item.first_item) begin
         win_eff    = '0;
         fill_eff   = '0;
         pos_eff    = {9'd0, item.payload_offset};
         sfound_eff = 1'b0;
         soff_eff   = '0;
         efound_eff = 1'b0;
         eoff_eff   = '0;
      end else begin
         win_eff    = window_ff;
         fill_eff   = fill_ff;
         pos_eff    = pos_ff;
         sfound_eff = sfound_ff;
         soff_eff   = soff_ff;
         efound_eff = efound_ff;
         eoff_eff   = eoff_ff;
      end
   end

   assign b1  = win_eff[7:0];
   assign b2  = win_eff[15:8];
   assign b3  = win_eff[23:16];
   assign cur = item.data_byte;

   // marker matches, only on bytes inside the packet
   assign hit_soi = item.byte_valid && (fill_eff >= 2'd2) && (b2 == imsc_pkg::MARK_FF)
                    && (b1 == imsc_pkg::MARK_SOI) && (cur == imsc_pkg::MARK_FF);
   assign hit_gif = item.byte_valid && (fill_eff == 2'd3) && (b3 == imsc_pkg::CH_G)
                    && (b2 == imsc_pkg::CH_I) && (b1 == imsc_pkg::CH_F)
                    && (cur == imsc_pkg::CH_8);
   assign hit_eoi = item.byte_valid && (fill_eff >= 2'd1) && (b1 == imsc_pkg::MARK_FF)
                    && (cur == imsc_pkg::MARK_EOI);

   // next state
   always_comb begin
      window_in = win_eff;
      fill_in   = fill_eff;
      pos_in    = pos_eff;
      sfound_in = sfound_eff;
      soff_in   = soff_eff;
      efound_in = efound_eff;
      eoff_in   = eoff_eff;
      if (hit_soi) begin
         sfound_in = 1'b1;
         soff_in   = pos_eff - 16'd2;
      end
      if (hit_gif) begin
         sfound_in = 1'b1;
         soff_in   = pos_eff - 16'd3;
      end
      if (hit_eoi) begin
         efound_in = 1'b1;
         eoff_in   = pos_eff + 16'd1;
      end
      if (item.byte_valid) begin
         window_in = {win_eff[15:0], cur};
         if (fill_eff != 2'd3) begin
            fill_in = fill_eff + 2'd1;
         end
         pos_in = pos_eff + 16'd1;
      end
   end

   // result word for a last item; fin forces the end to the packet length
   always_comb begin
      result.start_found  = sfound_in;
      result.start_offset = soff_in;
      if (item.fin_flag) begin
         result.end_found  = 1'b1;
         result.end_offset = pos_in;
      end else begin
         result.end_found  = efound_in;
         result.end_offset = eoff_in;
      end
   end

   // state registers; fin on a last item also sticks in the end record
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         fill_ff   <= '0;
         pos_ff    <= '0;
         sfound_ff <= 1'b0;
         soff_ff   <= '0;
         efound_ff <= 1'b0;
         eoff_ff   <= '0;
      end else if (step) begin
         window_ff <= window_in;
         fill_ff   <= fill_in;
         pos_ff    <= pos_in;
         sfound_ff <= sfound_in;
         soff_ff   <= soff_in;
         if (item.last_item) begin
            efound_ff <= result.end_found;
            eoff_ff   <= result.end_offset;
         end else begin
            efound_ff <= efound_in;
            eoff_ff   <= eoff_in;
         end
      end
   end

endmodule

`default_nettype wire

@@ sv/imsc_out_stage.sv @@
// result register for the image marker scanner
// depends on imsc_pkg
`default_nettype none

module imsc_out_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire imsc_pkg::result_type load_word,
   output logic                      room,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output imsc_pkg::result_type      out_word
);

   logic                 valid_ff, valid_in;
   imsc_pkg::result_type word_ff;

   // slot is free when empty or taken this cycle
   assign room      = !valid_ff || out_ready;
   assign valid_in  = load || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= load_word;
      end
   end

endmodule

`default_nettype wire

@@ sv/image_marker_scanner_core.sv @@
// Image marker scanner: takes one TCP payload byte per word and reports, on each
// packet's last word, the offset of the last JPEG or GIF start marker and the
// offset just past the last JPEG end marker (or the packet length when FIN is
// set). It accepts one word every clock; a result becomes valid once its last word
// has passed from the input register into the result register. The rate is set
// by the position and window update, which is combinational; only a stalled
// result register holding a pending last word stops intake. Words without
// first_item continue the current packet state.
// depends on imsc_pkg, imsc_in_stage, imsc_scan, imsc_out_stage
`default_nettype none

`include "image_marker_scanner_core_macros.svh"

module image_marker_scanner_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_byte_valid,
   input  wire logic        req_first_item,
   input  wire logic [6:0]  req_payload_offset,
   input  wire logic        req_last_item,
   input  wire logic        req_fin_flag,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_start_found,
   output logic [15:0]      rsp_start_offset,
   output logic             rsp_end_found,
   output logic [15:0]      rsp_end_offset
);

   imsc_pkg::item_type   req_item;
   imsc_pkg::item_type   held_item;
   imsc_pkg::result_type scan_result;
   imsc_pkg::result_type out_word;
   logic                 held_valid;
   logic                 room;
   logic                 step;
   logic                 load;

   // pack the input word
   always_comb begin
      req_item.data_byte      = req_data_byte;
      req_item.byte_valid     = req_byte_valid;
      req_item.first_item     = req_first_item;
      req_item.payload_offset = req_payload_offset;
      req_item.last_item      = req_last_item;
      req_item.fin_flag       = req_fin_flag;
   end

   // a held word moves on unless it is a last word facing a full result slot
   assign step = held_valid && (!held_item.last_item || room);
   assign load = step && held_item.last_item;

   imsc_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_item    (req_item),
      .step       (step),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   imsc_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (held_item),
      .result (scan_result)
   );

   imsc_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .load_word (scan_result),
      .room      (room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (out_word)
   );

   // unpack the result word
   assign rsp_start_found  = out_word.start_found;
   assign rsp_start_offset = out_word.start_offset;
   assign rsp_end_found    = out_word.end_found;
   assign rsp_end_offset   = out_word.end_offset;

   // checks
   `IMSC_ASSERT_NEXT(a_last_gives_rsp, load, rsp_valid, "last word did not produce a result")
   `IMSC_ASSERT_NEXT(a_no_rsp_invented, !rsp_valid && !load, !rsp_valid, "result without last word")
   `IMSC_ASSERT_NEXT(a_held_word_kept, held_valid && !step, held_valid && $stable(held_item),
                     "stalled input word was lost or changed")
   `IMSC_ASSERT(a_no_overwrite, !(load && rsp_valid && !rsp_ready), "pending result overwritten")

endmodule

`default_nettype wire

@@ test/tb_image_marker_scanner_core.sv @@
`timescale 1ns / 100ps
// testbench for image_marker_scanner_core: sends packets of payload words, predicts the
// marker report of each packet and checks every result word against that prediction
// depends on imsc_pkg and image_marker_scanner_core
module tb_image_marker_scanner_core;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 10;
   localparam int LONG_HOLD = 400;
   localparam int RANDOM_WORDS = 1500;
   localparam int RANDOM_REPORTS = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        req_byte_valid = 1'b0;
   logic        req_first_item = 1'b0;
   logic [6:0]  req_payload_offset = '0;
   logic        req_last_item = 1'b0;
   logic        req_fin_flag = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_start_found;
   logic [15:0] rsp_start_offset;
   logic        rsp_end_found;
   logic [15:0] rsp_end_offset;

   image_marker_scanner_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data_byte(req_data_byte),
      .req_byte_valid(req_byte_valid),
      .req_first_item(req_first_item),
      .req_payload_offset(req_payload_offset),
      .req_last_item(req_last_item),
      .req_fin_flag(req_fin_flag),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_start_found(rsp_start_found),
      .rsp_start_offset(rsp_start_offset),
      .rsp_end_found(rsp_end_found),
      .rsp_end_offset(rsp_end_offset)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   imsc_pkg::item_type   words_to_send[$];
   imsc_pkg::result_type expected_reports[$];
   int         reports_planned = 0;
   int         words_accepted = 0;
   int         reports_checked = 0;
   int         mismatches = 0;
   int         cycle_count = 0;
   int         send_idle = 0;
   int         recv_idle = 0;
   int         holds_done = 0;
   bit         hs_seen = 1'b0;
   bit         quiet;
   imsc_pkg::item_type   next_word;
   imsc_pkg::result_type due_report;

   // scanner state as the block should hold it
   logic [23:0] scan_window = '0;
   logic [1:0]  scan_fill = '0;
   logic [15:0] scan_pos = '0;
   logic        start_hit = 1'b0;
   logic [15:0] start_at = '0;
   logic        end_hit = 1'b0;
   logic [15:0] end_at = '0;

   // stretches with no idling on either side
   assign quiet = ((cycle_count / 3000) % 4) == 3;

   // idle length: mostly none or short, now and then long
   function automatic int pick_idle(input bit quiet_now);
      int r;
      r = $urandom_range(0, 99);
      if (quiet_now || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   // apply one accepted word to the scanner state, queue the report on a last word
   task automatic track_marker_word(input imsc_pkg::item_type w);
      logic [7:0] b1, b2, b3;
      imsc_pkg::result_type rep;
      if (w.first_item) begin
         scan_pos = {9'd0, w.payload_offset};
         scan_window = '0;
         scan_fill = '0;
         start_hit = 1'b0;
         start_at = '0;
         end_hit = 1'b0;
         end_at = '0;
      end
      b1 = scan_window[7:0];
      b2 = scan_window[15:8];
      b3 = scan_window[23:16];
      if (w.byte_valid) begin
         if (scan_fill >= 2 && b2 == imsc_pkg::MARK_FF && b1 == imsc_pkg::MARK_SOI
             && w.data_byte == imsc_pkg::MARK_FF) begin
            start_hit = 1'b1;
            start_at = scan_pos - 16'd2;
         end
         if (scan_fill == 3 && b3 == imsc_pkg::CH_G && b2 == imsc_pkg::CH_I
             && b1 == imsc_pkg::CH_F && w.data_byte == imsc_pkg::CH_8) begin
            start_hit = 1'b1;
            start_at = scan_pos - 16'd3;
         end
         if (scan_fill >= 1 && b1 == imsc_pkg::MARK_FF && w.data_byte == imsc_pkg::MARK_EOI) begin
            end_hit = 1'b1;
            end_at = scan_pos + 16'd1;
         end
         scan_window = {scan_window[15:0], w.data_byte};
         if (scan_fill != 2'd3) scan_fill = scan_fill + 2'd1;
         scan_pos = scan_pos + 16'd1;
      end
      if (w.last_item) begin
         // fin makes the packet length the end offset
         if (w.fin_flag) begin
            end_hit = 1'b1;
            end_at = scan_pos;
         end
         rep.start_found = start_hit;
         rep.start_offset = start_hit ? start_at : 16'd0;
         rep.end_found = end_hit;
         rep.end_offset = end_hit ? end_at : 16'd0;
         expected_reports = {expected_reports, rep};
      end
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   task automatic queue_word(input logic [7:0] data, input bit valid, input bit first,
                             input logic [6:0] offset, input bit last, input bit fin);
      imsc_pkg::item_type w;
      w.data_byte = data;
      w.byte_valid = valid;
      w.first_item = first;
      w.payload_offset = offset;
      w.last_item = last;
      w.fin_flag = fin;
      words_to_send = {words_to_send, w};
      if (last) reports_planned++;
   endtask

   // one packet with random content, sometimes headless, with skipped words inside
   task automatic queue_random_packet();
      logic [7:0] body[$];
      int len, pick, k;
      bit headless, lead_empty, tail_empty, first_now;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 160) : $urandom_range(0, 24);
      while (body.size() < len) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            body = {body, imsc_pkg::MARK_FF, imsc_pkg::MARK_SOI, imsc_pkg::MARK_FF};
         end else if (pick < 14) begin
            body = {body, imsc_pkg::CH_G, imsc_pkg::CH_I, imsc_pkg::CH_F, imsc_pkg::CH_8};
         end else if (pick < 22) begin
            body = {body, imsc_pkg::MARK_FF, imsc_pkg::MARK_EOI};
         end else if (pick < 60) begin
            case ($urandom_range(0, 6))
               0: body = {body, imsc_pkg::MARK_FF};
               1: body = {body, imsc_pkg::MARK_SOI};
               2: body = {body, imsc_pkg::MARK_EOI};
               3: body = {body, imsc_pkg::CH_G};
               4: body = {body, imsc_pkg::CH_I};
               5: body = {body, imsc_pkg::CH_F};
               default: body = {body, imsc_pkg::CH_8};
            endcase
         end else begin
            body = {body, 8'($urandom)};
         end
      end
      headless = ($urandom_range(0, 9) == 0);
      lead_empty = !headless && ($urandom_range(0, 9) == 0);
      tail_empty = ($urandom_range(0, 19) == 0);
      first_now = !headless;
      // empty packet or an opening word with no byte
      if (body.size() == 0 || lead_empty) begin
         queue_word(8'($urandom), 1'b0, first_now, 7'($urandom_range(40, 80)),
                    body.size() == 0, 1'($urandom));
         first_now = 1'b0;
      end
      for (k = 0; k < body.size(); k++) begin
         if (k > 0 && $urandom_range(0, 99) < 8)
            queue_word(8'($urandom), 1'b0, 1'b0, 7'($urandom), 1'b0, 1'($urandom));
         queue_word(body[k], 1'b1, first_now,
                    first_now ? 7'($urandom_range(40, 80)) : 7'($urandom),
                    (k == body.size() - 1) && !tail_empty, 1'($urandom));
         first_now = 1'b0;
      end
      if (body.size() != 0 && tail_empty)
         queue_word(8'($urandom), 1'b0, 1'b0, 7'($urandom), 1'b1, 1'($urandom));
   endtask

   // cycle counter and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // driver: next word goes out once the current one is taken
   always @(negedge clock) begin
      if (!reset && (!req_valid || hs_seen)) begin
         if (send_idle > 0) begin
            send_idle <= send_idle - 1;
            req_valid <= 1'b0;
         end else if (words_to_send.size() != 0) begin
            next_word = words_to_send.pop_front();
            req_data_byte <= next_word.data_byte;
            req_byte_valid <= next_word.byte_valid;
            req_first_item <= next_word.first_item;
            req_payload_offset <= next_word.payload_offset;
            req_last_item <= next_word.last_item;
            req_fin_flag <= next_word.fin_flag;
            req_valid <= 1'b1;
            send_idle <= pick_idle(quiet || words_to_send.size() > 2000);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls plus two long hold-offs that back the block up
   always @(negedge clock) begin
      if (!reset) begin
         if (recv_idle > 0) begin
            recv_idle <= recv_idle - 1;
            rsp_ready <= 1'b0;
         end else if (holds_done < 2 && reports_checked >= 20 + 50 * holds_done) begin
            recv_idle <= LONG_HOLD;
            holds_done <= holds_done + 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            recv_idle <= pick_idle(quiet);
         end
      end
   end

   // monitor: predict on accepted words, check accepted results
   always @(posedge clock) begin
      hs_seen <= req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            track_marker_word(imsc_pkg::item_type'({req_data_byte, req_byte_valid,
                                                    req_first_item, req_payload_offset,
                                                    req_last_item, req_fin_flag}));
            words_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               $display("%0t: result with none expected, start %0d/%0d end %0d/%0d", $time,
                        rsp_start_found, rsp_start_offset, rsp_end_found, rsp_end_offset);
               mismatches++;
            end else begin
               due_report = expected_reports.pop_front();
               check_field("start_found", due_report.start_found, rsp_start_found);
               check_field("start_offset", due_report.start_offset, rsp_start_offset);
               check_field("end_found", due_report.end_found, rsp_end_found);
               check_field("end_offset", due_report.end_offset, rsp_end_offset);
               reports_checked++;
            end
         end
      end
   end

   // stimulus and end of run
   initial begin
      int base;

      // headless word right after reset continues from position zero
      queue_word(imsc_pkg::MARK_FF, 1'b1, 1'b0, 7'h7F, 1'b0, 1'b1);
      queue_word(imsc_pkg::MARK_EOI, 1'b1, 1'b0, 7'h00, 1'b1, 1'b0);
      // empty packets, with and without fin
      queue_word(8'hFF, 1'b0, 1'b1, 7'd80, 1'b1, 1'b1);
      queue_word(8'h00, 1'b0, 1'b1, 7'd40, 1'b1, 1'b0);
      // single word packet with fin
      queue_word(8'h00, 1'b1, 1'b1, 7'd64, 1'b1, 1'b1);
      // jpeg start, skipped word, gif start, jpeg end split by a skipped word
      queue_word(imsc_pkg::MARK_FF, 1'b1, 1'b1, 7'd41, 1'b0, 1'b0);
      queue_word(imsc_pkg::MARK_SOI, 1'b1, 1'b0, 7'd0, 1'b0, 1'b0);
      queue_word(imsc_pkg::MARK_FF, 1'b1, 1'b0, 7'd0, 1'b0, 1'b0);
      queue_word(8'h55, 1'b0, 1'b0, 7'h2A, 1'b0, 1'b1);
      queue_word(imsc_pkg::CH_G, 1'b1, 1'b0, 7'd0, 1'b0, 1'b0);
      queue_word(imsc_pkg::CH_I, 1'b1, 1'b0, 7'd0, 1'b0, 1'b0);
      queue_word(imsc_pkg::CH_F, 1'b1, 1'b0, 7'd0, 1'b0, 1'b0);
      queue_word(imsc_pkg::CH_8, 1'b1, 1'b0, 7'd0, 1'b0, 1'b0);
      queue_word(imsc_pkg::MARK_FF, 1'b1, 1'b0, 7'd0, 1'b0, 1'b0);
      queue_word(8'hAA, 1'b0, 1'b0, 7'h55, 1'b0, 1'b0);
      queue_word(imsc_pkg::MARK_EOI, 1'b1, 1'b0, 7'd0, 1'b1, 1'b0);
      // markers cut by packet edges must not count
      queue_word(imsc_pkg::MARK_FF, 1'b1, 1'b1, 7'd50, 1'b0, 1'b0);
      queue_word(imsc_pkg::MARK_SOI, 1'b1, 1'b0, 7'd0, 1'b1, 1'b0);
      queue_word(imsc_pkg::MARK_FF, 1'b1, 1'b1, 7'd60, 1'b1, 1'b0);
      queue_word(imsc_pkg::MARK_EOI, 1'b1, 1'b1, 7'd70, 1'b1, 1'b0);
      queue_word(imsc_pkg::CH_G, 1'b1, 1'b1, 7'd45, 1'b0, 1'b0);
      queue_word(imsc_pkg::CH_I, 1'b1, 1'b0, 7'd0, 1'b0, 1'b0);
      queue_word(imsc_pkg::CH_F, 1'b1, 1'b0, 7'd0, 1'b1, 1'b0);
      queue_word(imsc_pkg::CH_8, 1'b1, 1'b1, 7'd77, 1'b1, 1'b1);

      // random packets
      base = words_to_send.size();
      reports_planned = 0;
      while (words_to_send.size() - base < RANDOM_WORDS || reports_planned < RANDOM_REPORTS)
         queue_random_packet();

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (words_to_send.size() != 0 || req_valid) @(posedge clock);
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d words accepted, %0d packet reports checked, %0d mismatches",
               words_accepted, reports_checked, mismatches);
      $display("covered headless words, empty packets, split markers and long result stalls");
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

@@ image_marker_scanner_core.f @@
+incdir+sv
sv/imsc_pkg.sv
sv/imsc_in_stage.sv
sv/imsc_scan.sv
sv/imsc_out_stage.sv
sv/image_marker_scanner_core.sv
test/tb_image_marker_scanner_core.sv
